/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL; empty bodies in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: property failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

/* rtl/core/mvt_pkg.sv */
// Types, constants and codes for the 4x4 matrix-vector transform block.
package mvt_pkg;

	localparam int DIM           = 4;
	localparam int ROW_W         = $clog2(DIM);
	localparam int WORD_W        = 32;
	localparam int PROD_W        = 2 * WORD_W;
	localparam int SUM_W         = PROD_W + 2;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [1:0] MODE_LOAD      = 2'd0;
	localparam logic [1:0] MODE_XFORM     = 2'd1;
	localparam logic [1:0] MODE_TRANSPOSE = 2'd2;
	localparam logic [1:0] MODE_SCALE     = 2'd3;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] row;
		logic [1:0] col;
		word_t      value;
		word_t      vec_x;
		word_t      vec_y;
		word_t      vec_z;
		word_t      vec_w;
	} item_t;

	typedef struct packed {
		word_t out_x;
		word_t out_y;
		word_t out_z;
		word_t out_w;
		logic  saturated;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic             accept;
		logic             issue;
		logic [ROW_W-1:0] issue_row;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pipe_busy;
	} status_t;

endpackage

/* rtl/core/matrix4_vector_transform_top.sv */
// Load and transpose never raise busy, so the next beat may follow at once.
// Transform and scale hold busy high from their accept until the pipeline has drained;
// one row per cycle goes through the four shared multipliers, then 3 pipeline stages.
// A transform result is strobed for one cycle, registered together with its last output word.
// arst_n clears the matrix to zero and returns the sequencer to idle.
`include "assert_macros.svh"

module matrix4_vector_transform_top #(
	parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  mvt_pkg::item_t   item,
	output mvt_pkg::result_t result,
	output logic             strobe
);
	import mvt_pkg::*;

	cmd_t    cmd;
	status_t status;

	mvt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (item.mode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	mvt_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result),
		.strobe (strobe)
	);

	`ASSERT_PROP(a_long_op_goes_busy, clk, arst_n, (start && !busy && (item.mode == MODE_XFORM || item.mode == MODE_SCALE)) |=> busy)
	`ASSERT_NEVER(a_no_strobe_while_issuing, clk, arst_n, strobe && cmd.issue)
	`ASSERT_PROP(a_strobe_follows_busy, clk, arst_n, strobe |-> $past(busy))

endmodule

/* rtl/core/mvt_ctrl.sv */
// Sequencer: accepts commands and issues one matrix row per cycle to the datapath.
module mvt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       mode,
	input  mvt_pkg::status_t status,
	output mvt_pkg::cmd_t    cmd,
	output logic             busy
);
	import mvt_pkg::*;

	state_t           state_q, state_d;
	logic [ROW_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		cmd.accept    = 1'b0;
		cmd.issue     = 1'b0;
		cmd.issue_row = cnt_q;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = start;
				cnt_d      = '0;
				if (start && (mode == MODE_XFORM || mode == MODE_SCALE)) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q == ROW_W'(DIM - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

/* rtl/core/mvt_dp.sv */
// Datapath: matrix registers, four shared multipliers, adder tree, floor shift and clamp.
module mvt_dp #(
	parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mvt_pkg::item_t   item,
	input  mvt_pkg::cmd_t    cmd,
	output mvt_pkg::status_t status,
	output mvt_pkg::result_t result,
	output logic             strobe
);
	import mvt_pkg::*;

	// {saturated, clamped word}
	function automatic logic [WORD_W:0] clamp_w(input logic signed [SUM_W-1:0] v);
		logic in_range;
		in_range = (&v[SUM_W-1:WORD_W-1]) | ~(|v[SUM_W-1:WORD_W-1]);
		if (in_range) begin
			clamp_w = {1'b0, v[WORD_W-1:0]};
		end else if (v[SUM_W-1]) begin
			clamp_w = {1'b1, 1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			clamp_w = {1'b1, 1'b0, {(WORD_W-1){1'b1}}};
		end
	endfunction

	word_t mat_q [DIM][DIM];
	word_t vec_q [DIM];
	word_t scal_q;
	logic  scale_q;

	// stage 1: products of one row
	logic signed [PROD_W-1:0]  prod_s1 [DIM];
	logic                      valid_s1;
	logic [ROW_W-1:0]          row_s1;
	// stage 2: pair sums
	logic signed [SUM_W-2:0]   pair_s2 [2];
	logic                      valid_s2;
	logic [ROW_W-1:0]          row_s2;
	// stage 3: row total
	logic signed [SUM_W-1:0]   sum_s3;
	logic                      valid_s3;
	logic [ROW_W-1:0]          row_s3;

	word_t                     out_q [DIM];
	logic                      sat_q;
	logic                      strobe_q;

	word_t                     mul_b  [DIM];
	logic signed [PROD_W-1:0]  mul_p  [DIM];
	logic [WORD_W:0]           sc_res [DIM];
	logic signed [SUM_W-1:0]   sum_sh;
	logic [WORD_W:0]           row_res;

	always_comb begin
		for (int c = 0; c < DIM; c++) begin
			mul_b[c]  = scale_q ? scal_q : vec_q[c];
			mul_p[c]  = PROD_W'(mat_q[cmd.issue_row][c]) * PROD_W'(mul_b[c]);
			sc_res[c] = clamp_w(SUM_W'(prod_s1[c] >>> FRAC_BITS));
		end
		sum_sh  = sum_s3 >>> FRAC_BITS;
		row_res = clamp_w(sum_sh);
	end

	// matrix store: load, transpose, scale write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < DIM; r++) begin
				for (int c = 0; c < DIM; c++) begin
					mat_q[r][c] <= '0;
				end
			end
		end else if (cmd.accept && item.mode == MODE_LOAD) begin
			mat_q[item.row][item.col] <= item.value;
		end else if (cmd.accept && item.mode == MODE_TRANSPOSE) begin
			for (int r = 0; r < DIM; r++) begin
				for (int c = 0; c < DIM; c++) begin
					mat_q[r][c] <= mat_q[c][r];
				end
			end
		end else if (valid_s1 && scale_q) begin
			// row was read at issue and is not read again this pass
			for (int c = 0; c < DIM; c++) begin
				mat_q[row_s1][c] <= sc_res[c][WORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			scal_q   <= item.value;
			vec_q[0] <= item.vec_x;
			vec_q[1] <= item.vec_y;
			vec_q[2] <= item.vec_z;
			vec_q[3] <= item.vec_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				scale_q <= (item.mode == MODE_SCALE);
			end
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			strobe_q <= valid_s3 && !scale_q && (row_s3 == ROW_W'(DIM - 1));
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= cmd.issue_row;
		for (int c = 0; c < DIM; c++) begin
			prod_s1[c] <= mul_p[c];
		end
		row_s2     <= row_s1;
		pair_s2[0] <= (SUM_W-1)'(prod_s1[0]) + (SUM_W-1)'(prod_s1[1]);
		pair_s2[1] <= (SUM_W-1)'(prod_s1[2]) + (SUM_W-1)'(prod_s1[3]);
		row_s3     <= row_s2;
		sum_s3     <= SUM_W'(pair_s2[0]) + SUM_W'(pair_s2[1]);
		if (valid_s3 && !scale_q) begin
			out_q[row_s3] <= row_res[WORD_W-1:0];
			sat_q         <= (row_s3 == '0) ? row_res[WORD_W] : (sat_q | row_res[WORD_W]);
		end
	end

	assign status.pipe_busy = valid_s1 | valid_s2 | valid_s3;

	assign result.out_x     = out_q[0];
	assign result.out_y     = out_q[1];
	assign result.out_z     = out_q[2];
	assign result.out_w     = out_q[3];
	assign result.saturated = sat_q;
	assign strobe           = strobe_q;

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the 4x4 matrix-vector transform block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mvt_pkg::*;

	localparam int FRAC       = FRAC_BITS_DEF;
	localparam int SETTLE_CYC = 16;
	localparam int SMALL_MAG  = 8 << 16;

	localparam logic signed [SUM_W-1:0] SAT_HI = 2147483647;
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - 1;

	localparam word_t W_MAX = 32'sh7FFF_FFFF;
	localparam word_t W_MIN = 32'sh8000_0000;
	localparam word_t W_ONE = 32'sh0001_0000;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	result_t result;
	logic    strobe;

	word_t   shadow_mat[DIM*DIM];
	result_t expected_xforms[$];
	int      mismatches;
	bit      allow_gaps;

	matrix4_vector_transform_top #(
		.FRAC_BITS(FRAC)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result(result),
		.strobe(strobe)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic word_t clamp_word(input logic signed [SUM_W-1:0] v, inout bit clipped);
		if (v > SAT_HI) begin
			clipped = 1'b1;
			return W_MAX;
		end
		if (v < SAT_LO) begin
			clipped = 1'b1;
			return W_MIN;
		end
		return v[WORD_W-1:0];
	endfunction

	// Updates the shadow matrix for load, transpose and scale; returns 1 when the beat yields a transform result.
	function automatic bit apply_to_matrix(input item_t it, output result_t res);
		word_t                    vec[DIM];
		word_t                    comp[DIM];
		word_t                    tmp;
		logic signed [SUM_W-1:0]  acc;
		logic signed [SUM_W-1:0]  prod;
		bit                       clipped;
		bit                       scale_clip;
		res = '0;
		clipped = 1'b0;
		scale_clip = 1'b0;
		case (it.mode)
			MODE_LOAD: begin
				shadow_mat[it.row * DIM + it.col] = it.value;
				return 1'b0;
			end
			MODE_TRANSPOSE: begin
				for (int i = 0; i < DIM; i++)
					for (int j = i + 1; j < DIM; j++) begin
						tmp = shadow_mat[i * DIM + j];
						shadow_mat[i * DIM + j] = shadow_mat[j * DIM + i];
						shadow_mat[j * DIM + i] = tmp;
					end
				return 1'b0;
			end
			MODE_SCALE: begin
				// clamp is silent here, no result carries it
				for (int i = 0; i < DIM * DIM; i++) begin
					prod = longint'(shadow_mat[i]) * longint'(it.value);
					shadow_mat[i] = clamp_word(prod >>> FRAC, scale_clip);
				end
				return 1'b0;
			end
			default: begin
				vec = '{it.vec_x, it.vec_y, it.vec_z, it.vec_w};
				for (int i = 0; i < DIM; i++) begin
					acc = '0;
					for (int j = 0; j < DIM; j++) begin
						prod = longint'(shadow_mat[i * DIM + j]) * longint'(vec[j]);
						acc = acc + prod;
					end
					// floor of the exact sum, same as summing per-term floors and carries
					comp[i] = clamp_word(acc >>> FRAC, clipped);
				end
				res.out_x = comp[0];
				res.out_y = comp[1];
				res.out_z = comp[2];
				res.out_w = comp[3];
				res.saturated = clipped;
				return 1'b1;
			end
		endcase
	endfunction

	function automatic word_t rand_word();
		case ($urandom_range(7))
			0: return word_t'($urandom);
			1: return $urandom_range(1) ? W_MAX : W_MIN;
			2: return $urandom_range(1) ? W_ONE : -W_ONE;
			default: return word_t'(int'($urandom_range(2 * SMALL_MAG)) - SMALL_MAG);
		endcase
	endfunction

	// mostly near unity so repeated scaling neither explodes nor collapses at once
	function automatic word_t rand_scalar();
		word_t s;
		if ($urandom_range(1)) begin
			s = word_t'($urandom_range(32'h0000_8000, 32'h0002_4000));
			return $urandom_range(3) == 0 ? -s : s;
		end
		return rand_word();
	endfunction

	task automatic send_cmd(input item_t it);
		result_t res;
		int      gap;
		if (allow_gaps && $urandom_range(3) == 0) begin
			gap = $urandom_range(1, 3);
			@(negedge clk);
			start <= 1'b0;
			item <= item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		if (apply_to_matrix(it, res))
			expected_xforms.push_back(res);
	endtask

	task automatic drive(input logic [1:0] mode, input logic [1:0] row, input logic [1:0] col,
			input word_t value, input word_t x, input word_t y, input word_t z, input word_t w);
		item_t it;
		it.mode = mode;
		it.row = row;
		it.col = col;
		it.value = value;
		it.vec_x = x;
		it.vec_y = y;
		it.vec_z = z;
		it.vec_w = w;
		send_cmd(it);
	endtask

	task automatic load_elem(input int r, input int c, input word_t v);
		drive(MODE_LOAD, 2'(r), 2'(c), v, word_t'($urandom), word_t'($urandom),
			word_t'($urandom), word_t'($urandom));
	endtask

	task automatic xform(input word_t x, input word_t y, input word_t z, input word_t w);
		drive(MODE_XFORM, 2'($urandom), 2'($urandom), word_t'($urandom), x, y, z, w);
	endtask

	task automatic other_op(input logic [1:0] mode, input word_t v);
		drive(mode, 2'($urandom), 2'($urandom), v, word_t'($urandom), word_t'($urandom),
			word_t'($urandom), word_t'($urandom));
	endtask

	task automatic test_load_extremes();
		for (int c = 0; c < DIM; c++)
			load_elem(0, c, W_MAX);
		for (int c = 0; c < DIM; c++)
			load_elem(1, c, W_MIN);
		load_elem(2, 1, W_ONE);
		load_elem(3, 3, -32'sd1);
		load_elem(3, 0, -W_ONE);
	endtask

	task automatic test_transform_extremes();
		xform(W_MAX, W_MAX, W_MAX, W_MAX);
		xform(W_MIN, W_MIN, W_MIN, W_MIN);
		xform(W_ONE, 2 * W_ONE, -3 * W_ONE, W_MIN);
		xform('0, '0, '0, '0);
	endtask

	task automatic test_transpose();
		other_op(MODE_TRANSPOSE, word_t'($urandom));
		xform(W_ONE, -W_ONE, 32'sd1, W_MAX);
		other_op(MODE_TRANSPOSE, word_t'($urandom));
	endtask

	task automatic test_scale();
		other_op(MODE_SCALE, W_ONE);
		other_op(MODE_SCALE, W_MAX);
		xform(W_ONE, W_ONE, W_ONE, W_ONE);
		other_op(MODE_SCALE, W_MIN);
		xform(W_ONE, -W_ONE, W_MAX, 32'sd3);
		other_op(MODE_SCALE, '0);
		xform(W_MAX, W_MIN, W_MAX, W_MIN);
	endtask

	task automatic test_random(input int n);
		int pick;
		for (int k = 0; k < n; k++) begin
			// last part runs back to back
			allow_gaps = (k < n - n / 5);
			pick = $urandom_range(99);
			if (pick < 3) begin
				for (int e = 0; e < DIM * DIM; e++)
					load_elem(e / DIM, e % DIM, rand_word());
			end else if (pick < 40)
				load_elem($urandom_range(3), $urandom_range(3), rand_word());
			else if (pick < 82)
				xform(rand_word(), rand_word(), rand_word(), rand_word());
			else if (pick < 90)
				other_op(MODE_TRANSPOSE, word_t'($urandom));
			else
				other_op(MODE_SCALE, rand_scalar());
		end
	endtask

	task automatic log_mismatch(input string what, input result_t want, input result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t mismatch (%s): exp x=%h y=%h z=%h w=%h sat=%b",
				$realtime, what, want.out_x, want.out_y, want.out_z, want.out_w,
				want.saturated);
			$display("    got x=%h y=%h z=%h w=%h sat=%b",
				got.out_x, got.out_y, got.out_z, got.out_w, got.saturated);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && strobe) begin
			if (expected_xforms.size() == 0)
				log_mismatch("unexpected beat", '0, result);
			else begin
				want = expected_xforms.pop_front();
				if (result.out_x !== want.out_x || result.out_y !== want.out_y ||
						result.out_z !== want.out_z || result.out_w !== want.out_w ||
						result.saturated !== want.saturated)
					log_mismatch("field", want, result);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		allow_gaps = 1'b1;
		mismatches = 0;
		foreach (shadow_mat[i])
			shadow_mat[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_load_extremes();
		test_transform_extremes();
		test_transpose();
		test_scale();
		// full reloads send 16 beats each, so this lands near 500 beats in all
		test_random(325);

		@(negedge clk);
		start <= 1'b0;
		while (expected_xforms.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		if (mismatches == 0 && expected_xforms.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#500us;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/mvt_pkg.sv
rtl/core/mvt_ctrl.sv
rtl/core/mvt_dp.sv
rtl/core/matrix4_vector_transform_top.sv
dv/tb_top.sv
